@@ hw/rtl/dsat_pkg.sv @@
// ----------------------------------------------------------------------------
// dsat_pkg
// Shared types, codes and defaults for the delivery sequence tracker.
// ----------------------------------------------------------------------------
package dsat_pkg;

    // Field widths.
    localparam int SEQ_W  = 32;
    localparam int AGE_W  = 16;
    localparam int OP_W   = 3;
    localparam int KIND_W = 3;

    // Default table depths.
    localparam int PEND_DEPTH_DEF = 16;
    localparam int ACK_DEPTH_DEF  = 16;

    // Timeout value after reset.
    localparam logic [AGE_W-1:0] TIMEOUT_RESET = 16'd1000;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_SEND_NEXT   = 3'd0;
    localparam logic [OP_W-1:0] OP_SEND_FORCED = 3'd1;
    localparam logic [OP_W-1:0] OP_RECEIVE     = 3'd2;
    localparam logic [OP_W-1:0] OP_ACK         = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK        = 3'd4;
    localparam logic [OP_W-1:0] OP_FLUSH       = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR       = 3'd6;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ASSIGNED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DISCARDED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SUCCESS   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FAILURE   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ACK_ENTRY = 3'd5;
    localparam logic [KIND_W-1:0] KIND_PEND_FULL = 3'd6;
    localparam logic [KIND_W-1:0] KIND_ACKQ_FULL = 3'd7;

    // Contents of one pending cell.
    typedef struct packed {
        logic             valid;
        logic [SEQ_W-1:0] seq;
        logic [AGE_W-1:0] age;
    } pend_entry_t;

    // Controls broadcast to every pending cell.
    typedef struct packed {
        logic shift;
        logic clr;
    } pend_ctrl_t;

endpackage

@@ hw/rtl/dsat_pend_cell.sv @@
// ----------------------------------------------------------------------------
// dsat_pend_cell
// One pending-delivery cell: valid flag, sequence number and age. It takes
// its neighbor's contents on a shift, or a new entry on a load; a clear drops valid.
// ----------------------------------------------------------------------------
module dsat_pend_cell
    import dsat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  pend_ctrl_t       ctrl,
    input  logic             load,
    input  logic [SEQ_W-1:0] wr_seq,
    input  pend_entry_t      nb,
    output pend_entry_t      cur
);

    logic             valid_reg;
    logic [SEQ_W-1:0] seq_reg;
    logic [AGE_W-1:0] age_reg;

    // The valid flag is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clr)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= nb.valid;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
    end

    // Number and age are only meaningful while the entry is valid.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            seq_reg <= nb.seq;
            age_reg <= nb.age;
        end
        else if (load)
        begin
            seq_reg <= wr_seq;
            age_reg <= '0;
        end
    end

    assign cur.valid = valid_reg;
    assign cur.seq   = seq_reg;
    assign cur.age   = age_reg;

endmodule

@@ hw/rtl/dsat_ack_cell.sv @@
// ----------------------------------------------------------------------------
// dsat_ack_cell
// One acknowledgement queue cell. It holds a received number and moves it
// one place toward the head on a shift.
// ----------------------------------------------------------------------------
module dsat_ack_cell
    import dsat_pkg::*;
(
    input  logic             clk,
    input  logic             shift,
    input  logic             load,
    input  logic [SEQ_W-1:0] wr_seq,
    input  logic [SEQ_W-1:0] nb_seq,
    output logic [SEQ_W-1:0] seq
);

    logic [SEQ_W-1:0] seq_reg;

    // Validity of the cell is tracked by the fill count in the top level.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            seq_reg <= nb_seq;
        end
        else if (load)
        begin
            seq_reg <= wr_seq;
        end
    end

    assign seq = seq_reg;

endmodule

@@ hw/rtl/delivery_seq_ack_tracker_core.sv @@
// ----------------------------------------------------------------------------
// delivery_seq_ack_tracker_core
// Send, send-forced and receive run through execute and finish; ack and tick
// add a pass that turns the pending cell ring once; flush adds one queue shift
// per result plus the empty check. Clear and the unused code go back to idle
// from execute and give no result. One item is in work at a time; output
// stalls can hold the sequencer. Reset clears numbering, valid flags, queue
// count and sets timeout to 1000.
// ----------------------------------------------------------------------------
module delivery_seq_ack_tracker_core
    import dsat_pkg::*;
#(
    parameter int PENDING_DEPTH = PEND_DEPTH_DEF,
    parameter int ACK_DEPTH     = ACK_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [AGE_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   op,
    input  logic [SEQ_W-1:0]  seq_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [KIND_W-1:0] kind,
    output logic [SEQ_W-1:0]  seq_out,
    output logic              last
);

    localparam int CNT_W  = $clog2(PENDING_DEPTH);
    localparam int ACNT_W = $clog2(ACK_DEPTH + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]        state_reg,     state_next;
    logic [OP_W-1:0]   op_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [SEQ_W-1:0]  expected_reg,  expected_next;
    logic [ACNT_W-1:0] ack_count_reg, ack_count_next;
    logic [CNT_W-1:0]  scan_cnt_reg,  scan_cnt_next;
    logic [AGE_W-1:0]  timeout_reg;
    logic              car_valid_reg, car_valid_next;
    logic [KIND_W-1:0] car_kind_reg,  car_kind_next;
    logic [SEQ_W-1:0]  car_seq_reg,   car_seq_next;
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] out_kind_reg,  out_kind_next;
    logic [SEQ_W-1:0]  out_seq_reg,   out_seq_next;
    logic              out_last_reg,  out_last_next;

    pend_entry_t              pend_cur  [PENDING_DEPTH];
    pend_entry_t              pend_nb   [PENDING_DEPTH];
    logic [PENDING_DEPTH-1:0] pend_valid_vec;
    logic [PENDING_DEPTH-1:0] free_oh;
    logic                     any_free;
    pend_ctrl_t               pend_ctrl;
    logic                     send_write;
    logic [SEQ_W-1:0]         send_seq;
    pend_entry_t              head_proc;

    logic [SEQ_W-1:0] ack_cur [ACK_DEPTH];
    logic             ack_shift;
    logic             rx_write;
    logic             ack_full;

    logic              out_free;
    logic              take;
    logic [KIND_W-1:0] emit_kind;
    logic [SEQ_W-1:0]  emit_seq;
    logic              head_hit;
    logic              head_fail;
    logic [AGE_W-1:0]  age_inc;

    // Pending cell ring: each cell hands its contents to the next lower one,
    // and the head's updated contents wrap around into the highest cell.
    genvar gi;
    generate
        for (gi = 0; gi < PENDING_DEPTH; gi++)
        begin : g_pend
            assign pend_valid_vec[gi] = pend_cur[gi].valid;
            if (gi == PENDING_DEPTH - 1)
            begin : g_wrap
                assign pend_nb[gi] = head_proc;
            end
            else
            begin : g_link
                assign pend_nb[gi] = pend_cur[gi + 1];
            end
            dsat_pend_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (pend_ctrl),
                .load   (send_write & free_oh[gi]),
                .wr_seq (send_seq),
                .nb     (pend_nb[gi]),
                .cur    (pend_cur[gi])
            );
        end
    endgenerate

    // Acknowledgement queue chain: entries move toward the head on a flush.
    generate
        for (gi = 0; gi < ACK_DEPTH; gi++)
        begin : g_ack
            dsat_ack_cell u_cell (
                .clk    (clk),
                .shift  (ack_shift),
                .load   (rx_write && (ack_count_reg == ACNT_W'(gi))),
                .wr_seq (seq_reg),
                .nb_seq ((gi == ACK_DEPTH - 1) ? ack_cur[gi] : ack_cur[(gi + 1) % ACK_DEPTH]),
                .seq    (ack_cur[gi])
            );
        end
    endgenerate

    // Lowest free pending slot as a one-hot vector.
    assign free_oh  = ~pend_valid_vec & (pend_valid_vec + PENDING_DEPTH'(1));
    assign any_free = ~&pend_valid_vec;
    assign ack_full = (ack_count_reg == ACNT_W'(ACK_DEPTH));
    assign send_seq = (op_reg == OP_SEND_NEXT) ? expected_reg : seq_reg;

    // Update of the head cell during an ack or tick pass.
    always_comb
    begin
        age_inc   = (pend_cur[0].age == '1) ? pend_cur[0].age : pend_cur[0].age + AGE_W'(1);
        head_hit  = pend_cur[0].valid && (pend_cur[0].seq == seq_reg);
        head_fail = pend_cur[0].valid && (age_inc > timeout_reg);
        head_proc = pend_cur[0];
        if (op_reg == OP_TICK)
        begin
            head_proc.valid = pend_cur[0].valid && !head_fail;
            head_proc.age   = age_inc;
        end
        else
        begin
            head_proc.valid = pend_cur[0].valid && !head_hit;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    // Sequencer. A finished result waits in the carry register until the
    // next one appears (not last) or the item ends (last).
    always_comb
    begin
        state_next     = state_reg;
        expected_next  = expected_reg;
        ack_count_next = ack_count_reg;
        scan_cnt_next  = scan_cnt_reg;
        car_valid_next = car_valid_reg;
        car_kind_next  = car_kind_reg;
        car_seq_next   = car_seq_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_kind_next  = out_kind_reg;
        out_seq_next   = out_seq_reg;
        out_last_next  = out_last_reg;
        pend_ctrl      = '0;
        send_write     = 1'b0;
        rx_write       = 1'b0;
        ack_shift      = 1'b0;
        take           = 1'b0;
        emit_kind      = KIND_ASSIGNED;
        emit_seq       = seq_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (op_reg) inside
                    OP_SEND_NEXT, OP_SEND_FORCED:
                    begin
                        take       = 1'b1;
                        emit_seq   = send_seq;
                        emit_kind  = any_free ? KIND_ASSIGNED : KIND_PEND_FULL;
                        send_write = any_free;
                        if (any_free && (op_reg == OP_SEND_NEXT))
                        begin
                            expected_next = expected_reg + SEQ_W'(1);
                        end
                        state_next = S_FIN;
                    end
                    OP_RECEIVE:
                    begin
                        if (!ack_full || out_free)
                        begin
                            if (ack_full)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_ACKQ_FULL;
                                out_seq_next   = seq_reg;
                                out_last_next  = 1'b0;
                            end
                            else
                            begin
                                rx_write       = 1'b1;
                                ack_count_next = ack_count_reg + ACNT_W'(1);
                            end
                            take = 1'b1;
                            if (seq_reg >= expected_reg)
                            begin
                                expected_next = seq_reg + SEQ_W'(1);
                                emit_kind     = KIND_ACCEPTED;
                            end
                            else
                            begin
                                emit_kind = KIND_DISCARDED;
                            end
                            state_next = S_FIN;
                        end
                    end
                    OP_ACK, OP_TICK:
                    begin
                        state_next = S_SCAN;
                    end
                    OP_FLUSH:
                    begin
                        state_next = S_FLUSH;
                    end
                    OP_CLEAR:
                    begin
                        pend_ctrl.clr  = 1'b1;
                        expected_next  = '0;
                        ack_count_next = '0;
                        state_next     = S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                // One cell reaches the head per step; a full turn restores order.
                emit_kind = (op_reg == OP_TICK) ? KIND_FAILURE : KIND_SUCCESS;
                emit_seq  = pend_cur[0].seq;
                if ((op_reg == OP_TICK) ? head_fail : head_hit)
                begin
                    take = !car_valid_reg || out_free;
                end
                if (take || !((op_reg == OP_TICK) ? head_fail : head_hit))
                begin
                    pend_ctrl.shift = 1'b1;
                    if (scan_cnt_reg == CNT_W'(PENDING_DEPTH - 1))
                    begin
                        scan_cnt_next = '0;
                        state_next    = S_FIN;
                    end
                    else
                    begin
                        scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                    end
                end
            end
            S_FLUSH:
            begin
                emit_kind = KIND_ACK_ENTRY;
                emit_seq  = ack_cur[0];
                if (ack_count_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (!car_valid_reg || out_free)
                begin
                    take           = 1'b1;
                    ack_shift      = 1'b1;
                    ack_count_next = ack_count_reg - ACNT_W'(1);
                end
            end
            S_FIN:
            begin
                if (!car_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = car_kind_reg;
                    out_seq_next   = car_seq_reg;
                    out_last_next  = 1'b1;
                    car_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A new result moves the waiting one out as a non-final result.
        if (take)
        begin
            if (car_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = car_kind_reg;
                out_seq_next   = car_seq_reg;
                out_last_next  = 1'b0;
            end
            car_valid_next = 1'b1;
            car_kind_next  = emit_kind;
            car_seq_next   = emit_seq;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            expected_reg  <= '0;
            ack_count_reg <= '0;
            scan_cnt_reg  <= '0;
            timeout_reg   <= TIMEOUT_RESET;
            car_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            expected_reg  <= expected_next;
            ack_count_reg <= ack_count_next;
            scan_cnt_reg  <= scan_cnt_next;
            car_valid_reg <= car_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg  <= op;
            seq_reg <= seq_in;
        end
        car_kind_reg <= car_kind_next;
        car_seq_reg  <= car_seq_next;
        out_kind_reg <= out_kind_next;
        out_seq_reg  <= out_seq_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign seq_out   = out_seq_reg;
    assign last      = out_last_reg;

    // The queue fill count never passes the queue depth.
    a_ack_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ack_count_reg <= ACNT_W'(ACK_DEPTH))
        else $error("ack queue count beyond depth");

    // No result is left waiting once the sequencer is idle.
    a_idle_carry_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !car_valid_reg)
        else $error("result left in carry register at idle");

    // The pass counter rests at zero outside a pass.
    a_scan_cnt_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SCAN) |-> (scan_cnt_reg == '0))
        else $error("pass counter not at rest");

    // A send that finds a free slot adds exactly one pending entry.
    a_send_fills_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && any_free &&
         (op_reg == OP_SEND_NEXT || op_reg == OP_SEND_FORCED))
        |=> ($countones(pend_valid_vec) == $past($countones(pend_valid_vec)) + 1))
        else $error("send did not add one pending entry");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Delivery sequence tracker testbench
// Drives send, receive, ack, tick, flush and clear transfers into the tracker
// core, predicts every result with a behavioral copy of the sequence counter,
// pending table and ack queue, and checks each result field by field. A short
// directed part, table fill bursts under receiver back-pressure and
// randomized phases at several timeout settings follow.
// ----------------------------------------------------------------------------
module testbench;
    import dsat_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PEND_N = PEND_DEPTH_DEF;
    localparam int ACK_N  = ACK_DEPTH_DEF;

    // Op code the block ignores.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    // Cycles an item with no results may still be in work.
    localparam int SETTLE_CYCLES = PEND_N + 8;
    localparam int DRAIN_LIMIT   = 20000;

    // Random items per timeout phase.
    localparam int PHASE_ITEMS = 28;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq;
        logic              last;
    } result_t;

    // Behavioral copy of the tracker state plus the queue of due results.
    class tracker_scoreboard;
        logic [AGE_W-1:0] timeout;
        logic [SEQ_W-1:0] next_seq;
        bit               pend_used [PEND_N];
        logic [SEQ_W-1:0] pend_num  [PEND_N];
        logic [AGE_W-1:0] pend_age  [PEND_N];
        logic [SEQ_W-1:0] ack_list  [ACK_N];
        int unsigned      ack_len;
        result_t          batch[$];
        result_t          due_results[$];
        int               errors;
        int               transfers_in;
        int               results_seen;
        bit [7:0]         kinds_seen;

        function void wipe_tables();
            next_seq = '0;
            ack_len  = 0;
            for (int i = 0; i < PEND_N; i++)
            begin
                pend_used[i] = 1'b0;
            end
        endfunction

        function void power_up();
            timeout = TIMEOUT_RESET;
            wipe_tables();
            due_results.delete();
            errors       = 0;
            transfers_in = 0;
            results_seen = 0;
            kinds_seen   = '0;
        endfunction

        function void add(logic [KIND_W-1:0] k, logic [SEQ_W-1:0] s);
            result_t r;
            r.kind = k;
            r.seq  = s;
            r.last = 1'b0;
            batch.insert(batch.size(), r);
            kinds_seen[k] = 1'b1;
        endfunction

        // A send takes the lowest free slot or reports the table as full.
        function void place(logic [SEQ_W-1:0] num, bit advance);
            int slot;
            slot = -1;
            for (int i = PEND_N - 1; i >= 0; i--)
            begin
                if (!pend_used[i])
                    slot = i;
            end
            if (slot < 0)
            begin
                add(KIND_PEND_FULL, num);
                return;
            end
            pend_used[slot] = 1'b1;
            pend_num[slot]  = num;
            pend_age[slot]  = '0;
            add(KIND_ASSIGNED, num);
            if (advance)
                next_seq = next_seq + 1;
        endfunction

        // Works out the results of one accepted transfer and queues them.
        function void note_transfer(logic [OP_W-1:0] code, logic [SEQ_W-1:0] num);
            batch.delete();
            transfers_in++;
            case (code)
                OP_SEND_NEXT:   place(next_seq, 1'b1);
                OP_SEND_FORCED: place(num, 1'b0);
                OP_RECEIVE:
                begin
                    if (ack_len < ACK_N)
                    begin
                        ack_list[ack_len] = num;
                        ack_len++;
                    end
                    else
                        add(KIND_ACKQ_FULL, num);
                    if (num >= next_seq)
                    begin
                        next_seq = num + 1;
                        add(KIND_ACCEPTED, num);
                    end
                    else
                        add(KIND_DISCARDED, num);
                end
                OP_ACK:
                begin
                    for (int i = 0; i < PEND_N; i++)
                    begin
                        if (pend_used[i] && pend_num[i] == num)
                        begin
                            pend_used[i] = 1'b0;
                            add(KIND_SUCCESS, num);
                        end
                    end
                end
                OP_TICK:
                begin
                    for (int i = 0; i < PEND_N; i++)
                    begin
                        if (pend_used[i])
                        begin
                            if (pend_age[i] != '1)
                                pend_age[i] = pend_age[i] + AGE_W'(1);
                            if (pend_age[i] > timeout)
                            begin
                                pend_used[i] = 1'b0;
                                add(KIND_FAILURE, pend_num[i]);
                            end
                        end
                    end
                end
                OP_FLUSH:
                begin
                    for (int i = 0; i < ack_len; i++)
                    begin
                        add(KIND_ACK_ENTRY, ack_list[i]);
                    end
                    ack_len = 0;
                end
                OP_CLEAR: wipe_tables();
                default: ;
            endcase
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                due_results.insert(due_results.size(), batch[i]);
        endfunction

        // Compares one result transfer with the oldest due result.
        function void check_result(logic [KIND_W-1:0] k, logic [SEQ_W-1:0] s, logic l);
            result_t want;
            results_seen++;
            if (due_results.size() == 0)
            begin
                $error("unexpected result: kind %0d seq_out %h last %0d", k, s, l);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (k !== want.kind)
            begin
                $error("kind: expected %0d, actual %0d", want.kind, k);
                errors++;
            end
            if (s !== want.seq)
            begin
                $error("seq_out: expected %h, actual %h", want.seq, s);
                errors++;
            end
            if (l !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, l);
                errors++;
            end
        endfunction

        // Returns the number of a random occupied slot, or the fallback.
        function logic [SEQ_W-1:0] any_pending(logic [SEQ_W-1:0] fallback);
            int used[$];
            for (int i = 0; i < PEND_N; i++)
            begin
                if (pend_used[i])
                    used.insert(used.size(), i);
            end
            if (used.size() == 0)
                return fallback;
            return pend_num[used[$urandom_range(used.size() - 1)]];
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [AGE_W-1:0]  cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [OP_W-1:0]   op = '0;
    logic [SEQ_W-1:0]  seq_in = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq_out;
    logic              last;

    tracker_scoreboard sb;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_left = 0;
    int timeout_writes = 0;

    delivery_seq_ack_tracker_core #(
        .PENDING_DEPTH (PEND_N),
        .ACK_DEPTH     (ACK_N)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .seq_in      (seq_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .seq_out     (seq_out),
        .last        (last)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= rx_idle_on && ($urandom_range(99) < 18);
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(kind, seq_out, last);
    end

    // Offers one item, with an optional random gap, until it is accepted.
    task automatic send_item(input logic [OP_W-1:0] code, input logic [SEQ_W-1:0] num);
        @(negedge clk);
        if (tx_idle_on)
        begin
            while ($urandom_range(99) < 18)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        op       <= code;
        seq_in   <= num;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_transfer(code, num);
    endtask

    // Waits until every due result has arrived and the block has gone quiet.
    task automatic drain();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.due_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [AGE_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.timeout = value;
        timeout_writes++;
    endtask

    // One random item, biased toward numbers the tracker currently holds.
    task automatic random_item();
        int unsigned      pick;
        logic [OP_W-1:0]  code;
        logic [SEQ_W-1:0] num;
        pick = $urandom_range(99);
        num  = $urandom();
        if (pick < 22)
            code = OP_SEND_NEXT;
        else if (pick < 30)
        begin
            code = OP_SEND_FORCED;
            if ($urandom_range(1) == 0)
                num = sb.any_pending(num);
        end
        else if (pick < 52)
        begin
            code = OP_RECEIVE;
            if ($urandom_range(3) != 0)
                num = sb.next_seq + $urandom_range(4) - 2;
        end
        else if (pick < 68)
        begin
            code = OP_ACK;
            if ($urandom_range(3) != 0)
                num = sb.any_pending(num);
        end
        else if (pick < 84)
            code = OP_TICK;
        else if (pick < 94)
            code = OP_FLUSH;
        else if (pick < 97)
            code = OP_CLEAR;
        else
            code = OP_UNUSED;
        send_item(code, num);
    endtask

    // Overall time limit.
    initial
    begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Main sequence.
    initial
    begin
        logic [AGE_W-1:0] phase_timeout [6];
        sb = new();
        sb.power_up();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty tables, ignored op, duplicates, wrap and discard.
        send_item(OP_FLUSH, '0);
        send_item(OP_ACK, '0);
        send_item(OP_TICK, '0);
        send_item(OP_UNUSED, 32'hFFFF_FFFF);
        send_item(OP_SEND_NEXT, '0);
        send_item(OP_SEND_FORCED, 32'hFFFF_FFFF);
        send_item(OP_SEND_FORCED, 32'd5);
        send_item(OP_SEND_FORCED, 32'd5);
        send_item(OP_ACK, 32'd5);
        send_item(OP_SEND_NEXT, '0);
        send_item(OP_RECEIVE, 32'hFFFF_FFFF);
        send_item(OP_RECEIVE, 32'd0);
        send_item(OP_RECEIVE, 32'd0);
        send_item(OP_RECEIVE, 32'h5555_AAAA);
        send_item(OP_FLUSH, '0);

        // Timeout zero fails everything on the next tick.
        write_timeout('0);
        send_item(OP_TICK, '0);
        write_timeout(16'd1);
        send_item(OP_SEND_NEXT, '0);
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);
        // Clear keeps the timeout.
        send_item(OP_SEND_FORCED, 32'hAAAA_5555);
        send_item(OP_CLEAR, '0);
        send_item(OP_SEND_NEXT, '0);
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);

        // Fill both tables while the receiver holds off, so the input stalls.
        write_timeout(16'hFFFF);
        @(posedge clk);
        hold_left = 150;
        for (int i = 0; i <= PEND_N; i++)
            send_item(OP_SEND_NEXT, $urandom());
        for (int i = 0; i <= ACK_N; i++)
            send_item(OP_RECEIVE, 32'd100 + i);
        send_item(OP_RECEIVE, 32'd0);
        // Sender pauses until every result has come.
        drain();
        send_item(OP_FLUSH, '0);
        send_item(OP_ACK, 32'd3);
        send_item(OP_TICK, '0);
        send_item(OP_CLEAR, '0);

        // Random phases at several timeouts; the third one runs without gaps.
        phase_timeout[0] = 16'd2;
        phase_timeout[1] = 16'd5;
        phase_timeout[2] = 16'd1;
        phase_timeout[3] = 16'hFFFF;
        phase_timeout[4] = 16'd0;
        phase_timeout[5] = AGE_W'($urandom_range(3, 40));
        for (int p = 0; p < 6; p++)
        begin
            write_timeout(phase_timeout[p]);
            tx_idle_on = (p != 2);
            rx_idle_on = (p != 2);
            if (p == 3)
            begin
                @(posedge clk);
                hold_left = 120;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_item();
        end

        // Wait for the last results, then report.
        drain();
        if (sb.due_results.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.due_results.size());
            sb.errors += sb.due_results.size();
        end
        $display("Covered %0d transfers in and %0d results out over %0d timeout settings.",
                 sb.transfers_in, sb.results_seen, timeout_writes);
        $display("Result kinds predicted (bit per kind, kind 7 leftmost): %b", sb.kinds_seen);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ delivery_seq_ack_tracker_core.f @@
hw/rtl/dsat_pkg.sv
hw/rtl/dsat_pend_cell.sv
hw/rtl/dsat_ack_cell.sv
hw/rtl/delivery_seq_ack_tracker_core.sv
tb/testbench.sv
